FILE: rtl/adpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpe_pkg
// Shared widths, field codes and helper functions for the data-processing
// execute core.
// ----------------------------------------------------------------------------
package adpe_pkg;

    localparam int REG_COUNT  = 16;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 48;

    // Item modes.
    localparam logic [1:0] MODE_EXEC  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Condition codes.
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // Data-processing opcodes.
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    // Shift types of a register operand.
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    function automatic logic f_cond_pass(input logic [3:0] cond, input t_flags fl);
        logic res;
        unique case (cond)
            COND_EQ: res = fl.z;
            COND_NE: res = !fl.z;
            COND_GE: res = (fl.n == fl.v);
            COND_LT: res = (fl.n != fl.v);
            COND_GT: res = !fl.z && (fl.n == fl.v);
            COND_LE: res = fl.z || (fl.n != fl.v);
            COND_AL: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic f_op_defined(input logic [3:0] op);
        logic res;
        unique case (op)
            OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
            OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    // Returns {shifter carry, operand 2}.
    function automatic logic [DATA_W:0] f_operand_two(
        input logic [DATA_W-1:0] instr,
        input logic [DATA_W-1:0] rm_val,
        input logic              cin
    );
        logic [2*DATA_W-1:0] dbl;
        logic [DATA_W:0]     ext;
        logic [DATA_W-1:0]   imm32;
        logic [4:0]          rot;
        logic [4:0]          amt;
        logic [DATA_W:0]     res;
        dbl   = '0;
        ext   = '0;
        imm32 = {{(DATA_W-8){1'b0}}, instr[7:0]};
        rot   = {instr[11:8], 1'b0};
        amt   = instr[11:7];
        if (instr[25]) begin
            dbl = {imm32, imm32} >> rot;
            res = (rot == 5'd0) ? {cin, imm32} : {dbl[DATA_W-1], dbl[DATA_W-1:0]};
        end else begin
            case (instr[6:5])
                SH_LSL: begin
                    ext = {1'b0, rm_val} << amt;
                    res = (amt == 5'd0) ? {cin, rm_val} : ext;
                end
                SH_LSR: begin
                    ext = {rm_val, 1'b0} >> amt;
                    res = (amt == 5'd0) ? {rm_val[DATA_W-1], {DATA_W{1'b0}}}
                                        : {ext[0], ext[DATA_W:1]};
                end
                SH_ASR: begin
                    ext = {rm_val, 1'b0};
                    ext = $unsigned($signed(ext) >>> amt);
                    res = (amt == 5'd0) ? {rm_val[DATA_W-1], {DATA_W{rm_val[DATA_W-1]}}}
                                        : {ext[0], ext[DATA_W:1]};
                end
                default: begin
                    dbl = {rm_val, rm_val} >> amt;
                    res = (amt == 5'd0) ? {rm_val[0], cin, rm_val[DATA_W-1:1]}
                                        : {dbl[DATA_W-1], dbl[DATA_W-1:0]};
                end
            endcase
        end
        return res;
    endfunction

endpackage

FILE: rtl/alu_data_processing_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_data_processing_execute_core
// Executes 32-bit data-processing instruction words against a sixteen-entry
// register file and NZCV flags, and services register write and read items.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata fields (lowest bit first)
// s_axis    in   mode[1:0], instruction[33:2], reg_index[37:34],
//                write_value[69:38], zero fill [71:70]
// m_axis    out  executed[0], wrote_register[1], dest_index[5:2],
//                result_value[37:6], flags_nzcv[41:38], zero fill [47:42]
//
// One transaction is accepted per cycle while the output is not stalled:
// the accepting edge captures the register file reads and the item, and
// the edge on which the execute stage advances computes the shift, the
// ALU operation and the write back and loads the output register, which
// raises m_axis_tvalid. A write back can land on the same edge that the
// next item reads the memory, so the written entry and value are held
// and forwarded. Reset clears the flags and the per-entry valid bits; an
// entry never written reads as zero, so no clearing pass is needed.
// A stalled output holds the execute stage, which in turn stalls the input.
//
module alu_data_processing_execute_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mode, instruction, reg_index, write_value
    input  logic [adpe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // executed, wrote_register, dest_index, result_value, flags_nzcv
    output logic [adpe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW = adpe_pkg::REG_IDX_W;
    localparam int DW = adpe_pkg::DATA_W;

    // Input field unpacking.
    logic [1:0]    in_mode;
    logic [DW-1:0] in_instr;
    logic [IW-1:0] in_idx;
    logic [DW-1:0] in_wval;
    logic [IW-1:0] rd_addr_a;
    logic [IW-1:0] rd_addr_b;
    logic          s_fire;

    assign in_mode  = s_axis_tdata[1:0];
    assign in_instr = s_axis_tdata[33:2];
    assign in_idx   = s_axis_tdata[37:34];
    assign in_wval  = s_axis_tdata[69:38];

    // Port A reads Rn; port B reads Rm, or the requested register in read mode.
    assign rd_addr_a = in_instr[19:16];
    assign rd_addr_b = (in_mode == adpe_pkg::MODE_READ) ? in_idx : in_instr[3:0];

    // Register file storage and its read ports.
    logic [DW-1:0]        r_mem [adpe_pkg::REG_COUNT];
    logic [adpe_pkg::REG_COUNT-1:0] r_vld;
    logic [DW-1:0]        r_rd_a;
    logic [DW-1:0]        r_rd_b;
    logic                 r_rd_a_vld;
    logic                 r_rd_b_vld;

    // Execute stage registers.
    logic                 r_s1_valid;
    logic [1:0]           r_s1_mode;
    logic [DW-1:0]        r_s1_instr;
    logic [IW-1:0]        r_s1_idx;
    logic [DW-1:0]        r_s1_wval;
    logic [IW-1:0]        r_s1_addr_b;

    // Forwarding of the write that landed on the read edge.
    logic                 r_fwd_valid;
    logic [IW-1:0]        r_fwd_idx;
    logic [DW-1:0]        r_fwd_data;

    adpe_pkg::t_flags     r_flags;
    adpe_pkg::t_flags     n_flags;

    logic                 r_m_valid;
    logic [adpe_pkg::OUT_TDATA_W-1:0] r_m_data;

    logic                 s1_adv;

    assign s1_adv        = r_s1_valid && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Operand values after the valid-bit mask and forwarding.
    logic [DW-1:0] a_val;
    logic [DW-1:0] b_val;

    always_comb begin
        a_val = r_rd_a_vld ? r_rd_a : '0;
        if (r_fwd_valid && (r_fwd_idx == r_s1_instr[19:16])) begin
            a_val = r_fwd_data;
        end
        b_val = r_rd_b_vld ? r_rd_b : '0;
        if (r_fwd_valid && (r_fwd_idx == r_s1_addr_b)) begin
            b_val = r_fwd_data;
        end
    end

    // Execute: shift, ALU operation and flag update.
    logic [3:0]    op;
    logic          reg_shift;
    logic          exec;
    logic [DW:0]   op2_c;
    logic [DW-1:0] op2;
    logic [DW-1:0] add_x;
    logic [DW-1:0] add_y;
    logic          is_sub;
    logic [DW:0]   sum;
    logic [DW-1:0] res;
    logic          res_c;
    logic          writes;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [DW-1:0] wr_data;
    logic          o_exec;
    logic          o_wrote;
    logic [IW-1:0] o_dest;
    logic [DW-1:0] o_value;

    always_comb begin
        op        = r_s1_instr[24:21];
        reg_shift = !r_s1_instr[25] && r_s1_instr[4];
        exec      = (r_s1_mode == adpe_pkg::MODE_EXEC)
                    && adpe_pkg::f_cond_pass(r_s1_instr[31:28], r_flags)
                    && adpe_pkg::f_op_defined(op) && !reg_shift;
        op2_c     = adpe_pkg::f_operand_two(r_s1_instr, b_val, r_flags.c);
        op2       = op2_c[DW-1:0];

        // One adder serves ADD, SUB, RSB and CMP; subtraction adds the
        // complement, so the carry out is the no-borrow flag.
        is_sub = (op != adpe_pkg::OP_ADD);
        add_x  = (op == adpe_pkg::OP_RSB) ? op2 : a_val;
        add_y  = (op == adpe_pkg::OP_RSB) ? a_val : op2;
        sum    = {1'b0, add_x} + {1'b0, (is_sub ? ~add_y : add_y)} + {{DW{1'b0}}, is_sub};

        res    = op2;
        res_c  = op2_c[DW];
        writes = 1'b1;
        case (op)
            adpe_pkg::OP_AND: res = a_val & op2;
            adpe_pkg::OP_EOR: res = a_val ^ op2;
            adpe_pkg::OP_TST: begin
                res    = a_val & op2;
                writes = 1'b0;
            end
            adpe_pkg::OP_TEQ: begin
                res    = a_val ^ op2;
                writes = 1'b0;
            end
            adpe_pkg::OP_SUB, adpe_pkg::OP_RSB, adpe_pkg::OP_ADD: begin
                res   = sum[DW-1:0];
                res_c = sum[DW];
            end
            adpe_pkg::OP_CMP: begin
                res    = sum[DW-1:0];
                res_c  = sum[DW];
                writes = 1'b0;
            end
            adpe_pkg::OP_ORR: res = a_val | op2;
            default:          res = op2;
        endcase

        n_flags = r_flags;
        if (exec && r_s1_instr[20]) begin
            n_flags.n = res[DW-1];
            n_flags.z = (res == '0);
            n_flags.c = res_c;
        end

        o_exec  = 1'b0;
        o_wrote = 1'b0;
        o_dest  = '0;
        o_value = '0;
        wr_en   = 1'b0;
        wr_idx  = r_s1_instr[15:12];
        wr_data = res;
        if (r_s1_mode == adpe_pkg::MODE_WRITE) begin
            wr_en   = 1'b1;
            wr_idx  = r_s1_idx;
            wr_data = r_s1_wval;
            o_wrote = 1'b1;
            o_dest  = r_s1_idx;
            o_value = r_s1_wval;
        end else if (r_s1_mode == adpe_pkg::MODE_READ) begin
            o_dest  = r_s1_idx;
            o_value = b_val;
        end else if (exec) begin
            o_exec = 1'b1;
            if (writes) begin
                wr_en   = 1'b1;
                o_wrote = 1'b1;
                o_dest  = wr_idx;
                o_value = res;
            end
        end
        wr_en = wr_en && s1_adv;
    end

    // Memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (s_fire) begin
            r_rd_a     <= r_mem[rd_addr_a];
            r_rd_b     <= r_mem[rd_addr_b];
            r_rd_a_vld <= r_vld[rd_addr_a];
            r_rd_b_vld <= r_vld[rd_addr_b];
        end
    end

    // Payload registers of the execute stage and the forwarding path.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_mode   <= in_mode;
            r_s1_instr  <= in_instr;
            r_s1_idx    <= in_idx;
            r_s1_wval   <= in_wval;
            r_s1_addr_b <= rd_addr_b;
            r_fwd_idx   <= wr_idx;
            r_fwd_data  <= wr_data;
        end
        if (s1_adv) begin
            r_m_data <= {{(adpe_pkg::OUT_TDATA_W - 42){1'b0}},
                         n_flags, o_value, o_dest, o_wrote, o_exec};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_flags     <= '0;
            r_s1_valid  <= 1'b0;
            r_m_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (s1_adv) begin
                r_flags <= n_flags;
            end
            if (s_fire) begin
                // The forward is only meaningful for the write on this read edge.
                r_fwd_valid <= wr_en;
            end
            if (s_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: tb/sv/tb_alu_data_processing_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alu_data_processing_execute_core
// Self-checking bench for the data-processing execute core. A short
// directed script covers register access, every opcode and condition, the
// shifter corner cases and the items that never execute. A long random run
// follows. Every transaction is predicted by an architectural model kept in
// the bench, and each output transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_alu_data_processing_execute_core;

    // Codes that the package does not name, used to hit the items that
    // never execute.
    localparam logic [1:0] MODE_NONE      = 2'd3;
    localparam logic [3:0] COND_HS        = 4'd2;
    localparam logic [3:0] COND_NV        = 4'd15;
    localparam logic [3:0] OP_RSC         = 4'd7;
    localparam logic [11:0] REG_SHIFT_BIT = 12'h010;

    localparam int SCRIPT_LEN  = 25;
    localparam int RANDOM_LEN  = 1325;
    localparam int IDLE_PCT    = 37;
    localparam int CALM_FROM   = 800;
    localparam int CALM_TO     = 1000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 150;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 400000;

    // One output transaction, packed so that it lines up with tdata[41:0].
    typedef struct packed {
        logic [3:0]  flags;
        logic [31:0] value;
        logic [3:0]  dest;
        logic        wrote;
        logic        executed;
    } t_exec_result;

    typedef struct packed {
        logic [1:0]   mode;
        logic [31:0]  ins;
        logic [3:0]   idx;
        logic [31:0]  wv;
        logic         typed;
        t_exec_result want;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // mode, instruction, reg_index, write_value
    logic [adpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // executed, wrote_register, dest_index, result_value, flags_nzcv
    logic [adpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Architectural state of the predictor.
    logic [31:0]      gpr [adpe_pkg::REG_COUNT];
    adpe_pkg::t_flags psr;

    t_exec_result retire_q [$];
    t_stim_row    script [SCRIPT_LEN];
    t_exec_result mon_got;
    t_exec_result mon_want;
    int           sent_cnt;
    int           retired;
    int           mismatches;
    int           cycle_cnt;

    alu_data_processing_execute_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Instruction word builders.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] dp(input logic [3:0] cond, input logic imm,
                                       input logic [3:0] op, input logic s,
                                       input logic [3:0] rn, input logic [3:0] rd,
                                       input logic [11:0] op2);
        return {cond, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [11:0] imm_op(input logic [3:0] rot, input logic [7:0] val);
        return {rot, val};
    endfunction

    function automatic logic [11:0] reg_op(input logic [4:0] amt, input logic [1:0] sh,
                                           input logic [3:0] rm);
        return {amt, sh, 1'b0, rm};
    endfunction

    function automatic t_exec_result rslt(input logic ex, input logic wr,
                                          input logic [3:0] dest, input logic [31:0] val,
                                          input logic [3:0] fl);
        t_exec_result r;
        r.executed = ex;
        r.wrote    = wr;
        r.dest     = dest;
        r.value    = val;
        r.flags    = fl;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Architectural step: applies one input transaction to the bench's copy
    // of the register file and flags and returns the result it must retire.
    // ------------------------------------------------------------------------
    function automatic void arch_step(input logic [1:0] md, input logic [31:0] ins,
                                      input logic [3:0] ix, input logic [31:0] wv,
                                      output t_exec_result r);
        logic        pass;
        logic        known_op;
        logic        writes;
        logic        sc;
        logic        c;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic [31:0] res;
        logic [32:0] sum;
        int          amt;
        int          rot;

        r = '0;
        if (md == adpe_pkg::MODE_WRITE) begin
            gpr[ix] = wv;
            r.wrote = 1'b1;
            r.dest  = ix;
            r.value = wv;
        end else if (md == adpe_pkg::MODE_READ) begin
            r.dest  = ix;
            r.value = gpr[ix];
        end else if (md == adpe_pkg::MODE_EXEC) begin
            case (ins[31:28])
                adpe_pkg::COND_EQ: pass = psr.z;
                adpe_pkg::COND_NE: pass = !psr.z;
                adpe_pkg::COND_GE: pass = (psr.n == psr.v);
                adpe_pkg::COND_LT: pass = (psr.n != psr.v);
                adpe_pkg::COND_GT: pass = !psr.z && (psr.n == psr.v);
                adpe_pkg::COND_LE: pass = psr.z || (psr.n != psr.v);
                adpe_pkg::COND_AL: pass = 1'b1;
                default:           pass = 1'b0;
            endcase
            case (ins[24:21])
                adpe_pkg::OP_AND, adpe_pkg::OP_EOR, adpe_pkg::OP_SUB,
                adpe_pkg::OP_RSB, adpe_pkg::OP_ADD, adpe_pkg::OP_TST,
                adpe_pkg::OP_TEQ, adpe_pkg::OP_CMP, adpe_pkg::OP_ORR,
                adpe_pkg::OP_MOV: known_op = 1'b1;
                default:          known_op = 1'b0;
            endcase
            // A register-specified shift amount is outside the supported set.
            if (pass && known_op && !(!ins[25] && ins[4])) begin
                // Operand 2 and the shifter carry.
                if (ins[25]) begin
                    rot = 2 * int'(ins[11:8]);
                    v   = {24'd0, ins[7:0]};
                    if (rot == 0) begin
                        b  = v;
                        sc = psr.c;
                    end else begin
                        b  = (v >> rot) | (v << (32 - rot));
                        sc = b[31];
                    end
                end else begin
                    v   = gpr[ins[3:0]];
                    amt = int'(ins[11:7]);
                    case (ins[6:5])
                        adpe_pkg::SH_LSL: begin
                            b  = (amt == 0) ? v : (v << amt);
                            sc = (amt == 0) ? psr.c : v[32 - amt];
                        end
                        adpe_pkg::SH_LSR: begin
                            // An amount of zero encodes a shift by 32.
                            b  = (amt == 0) ? 32'd0 : (v >> amt);
                            sc = (amt == 0) ? v[31] : v[amt - 1];
                        end
                        adpe_pkg::SH_ASR: begin
                            b  = (amt == 0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
                            sc = (amt == 0) ? v[31] : v[amt - 1];
                        end
                        default: begin
                            // An amount of zero is a one-bit rotate through carry.
                            if (amt == 0) begin
                                b  = {psr.c, v[31:1]};
                                sc = v[0];
                            end else begin
                                b  = (v >> amt) | (v << (32 - amt));
                                sc = b[31];
                            end
                        end
                    endcase
                end

                a      = gpr[ins[19:16]];
                c      = sc;
                writes = 1'b1;
                case (ins[24:21])
                    adpe_pkg::OP_AND: res = a & b;
                    adpe_pkg::OP_EOR: res = a ^ b;
                    adpe_pkg::OP_SUB: begin
                        res = a - b;
                        c   = (a >= b);
                    end
                    adpe_pkg::OP_RSB: begin
                        res = b - a;
                        c   = (b >= a);
                    end
                    adpe_pkg::OP_ADD: begin
                        sum = {1'b0, a} + {1'b0, b};
                        res = sum[31:0];
                        c   = sum[32];
                    end
                    adpe_pkg::OP_TST: begin
                        res    = a & b;
                        writes = 1'b0;
                    end
                    adpe_pkg::OP_TEQ: begin
                        res    = a ^ b;
                        writes = 1'b0;
                    end
                    adpe_pkg::OP_CMP: begin
                        res    = a - b;
                        c      = (a >= b);
                        writes = 1'b0;
                    end
                    adpe_pkg::OP_ORR: res = a | b;
                    default:          res = b;
                endcase

                r.executed = 1'b1;
                if (writes) begin
                    gpr[ins[15:12]] = res;
                    r.wrote = 1'b1;
                    r.dest  = ins[15:12];
                    r.value = res;
                end
                // The S bit updates N, Z and C; V is never touched.
                if (ins[20]) begin
                    psr.n = res[31];
                    psr.z = (res == 32'd0);
                    psr.c = c;
                end
            end
        end
        r.flags = psr;
    endfunction

    // ------------------------------------------------------------------------
    // Random item source. Most items execute instructions with a condition
    // and opcode that are defined, so the flags and registers keep moving;
    // the rest are register accesses, undefined encodings and unused modes.
    // ------------------------------------------------------------------------
    task automatic draw_item(output logic [1:0] md, output logic [31:0] ins,
                             output logic [3:0] ix, output logic [31:0] wv);
        int unsigned pick;
        pick = $urandom_range(99);
        md   = (pick < 68) ? adpe_pkg::MODE_EXEC : (pick < 84) ? adpe_pkg::MODE_WRITE :
               (pick < 96) ? adpe_pkg::MODE_READ : MODE_NONE;
        ins  = $urandom;
        ix   = 4'($urandom_range(15));
        case ($urandom_range(7))
            0:       wv = 32'h0000_0000;
            1:       wv = 32'hFFFF_FFFF;
            2:       wv = 32'h8000_0000;
            3:       wv = 32'h7FFF_FFFF;
            default: wv = $urandom;
        endcase

        pick = $urandom_range(99);
        if (pick < 70) begin
            ins[31:28] = adpe_pkg::COND_AL;
        end else if (pick < 95) begin
            case ($urandom_range(5))
                0:       ins[31:28] = adpe_pkg::COND_EQ;
                1:       ins[31:28] = adpe_pkg::COND_NE;
                2:       ins[31:28] = adpe_pkg::COND_GE;
                3:       ins[31:28] = adpe_pkg::COND_LT;
                4:       ins[31:28] = adpe_pkg::COND_GT;
                default: ins[31:28] = adpe_pkg::COND_LE;
            endcase
        end

        if ($urandom_range(99) < 90) begin
            case ($urandom_range(9))
                0:       ins[24:21] = adpe_pkg::OP_AND;
                1:       ins[24:21] = adpe_pkg::OP_EOR;
                2:       ins[24:21] = adpe_pkg::OP_SUB;
                3:       ins[24:21] = adpe_pkg::OP_RSB;
                4:       ins[24:21] = adpe_pkg::OP_ADD;
                5:       ins[24:21] = adpe_pkg::OP_TST;
                6:       ins[24:21] = adpe_pkg::OP_TEQ;
                7:       ins[24:21] = adpe_pkg::OP_CMP;
                8:       ins[24:21] = adpe_pkg::OP_ORR;
                default: ins[24:21] = adpe_pkg::OP_MOV;
            endcase
        end

        // Keep register-specified shifts rare and zero shift amounts common.
        if (!ins[25] && $urandom_range(99) < 90) begin
            ins[4] = 1'b0;
        end
        if ($urandom_range(99) < 20) begin
            ins[11:7] = 5'd0;
        end
    endtask

    // Quiet window: neither side idles while it is open.
    function automatic bit calm();
        return (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);
    endfunction

    // Offers one transaction, with random idle cycles ahead of it, and
    // returns at the edge where it is accepted.
    task automatic offer(input logic [1:0] md, input logic [31:0] ins,
                         input logic [3:0] ix, input logic [31:0] wv);
        while (!calm() && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, wv, ix, ins, md};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sent_cnt++;
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", retired, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed script, then the random run.
    // ------------------------------------------------------------------------
    initial begin
        int           k;
        t_stim_row    row;
        t_exec_result want;
        logic [1:0]   md;
        logic [31:0]  ins;
        logic [3:0]   ix;
        logic [31:0]  wv;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        sent_cnt   = 0;
        retired    = 0;
        mismatches = 0;
        for (k = 0; k < adpe_pkg::REG_COUNT; k++) begin
            gpr[k] = 32'd0;
        end
        psr = '0;

        // Expected results are typed in only where they follow directly from
        // reset or from the item itself; all other rows use the predictor.
        script = '{
            // Register access straight after reset, and an unused mode.
            '{adpe_pkg::MODE_READ, 32'd0, 4'd0, 32'd0, 1'b1,
              rslt(1'b0, 1'b0, 4'd0, 32'd0, 4'd0)},
            '{adpe_pkg::MODE_WRITE, 32'd0, 4'd1, 32'hFFFF_FFFF, 1'b1,
              rslt(1'b0, 1'b1, 4'd1, 32'hFFFF_FFFF, 4'd0)},
            '{adpe_pkg::MODE_WRITE, 32'd0, 4'd2, 32'h8000_0000, 1'b1,
              rslt(1'b0, 1'b1, 4'd2, 32'h8000_0000, 4'd0)},
            '{adpe_pkg::MODE_WRITE, 32'd0, 4'd15, 32'h0000_0001, 1'b1,
              rslt(1'b0, 1'b1, 4'd15, 32'h0000_0001, 4'd0)},
            '{MODE_NONE, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1'b1,
              rslt(1'b0, 1'b0, 4'd0, 32'd0, 4'd0)},
            // Unrotated immediate keeps C; an adder overflow to zero sets Z and C.
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b1, 4'd9, 4'd3,
                 imm_op(4'd0, 8'h00)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_ADD, 1'b1, 4'd1, 4'd4,
                 imm_op(4'd0, 8'h01)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_EQ, 1'b0, adpe_pkg::OP_ORR, 1'b0, 4'd2, 4'd5,
                 reg_op(5'd0, adpe_pkg::SH_LSL, 4'd15)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_NE, 1'b0, adpe_pkg::OP_AND, 1'b1, 4'd1, 4'd6,
                 reg_op(5'd3, adpe_pkg::SH_LSL, 4'd1)),
              4'd0, 32'd0, 1'b0, '0},
            // Zero shift amounts: LSR and ASR by 32, ROR as rotate through carry.
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_SUB, 1'b1, 4'd15, 4'd7,
                 reg_op(5'd0, adpe_pkg::SH_LSR, 4'd1)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_RSB, 1'b1, 4'd15, 4'd8,
                 reg_op(5'd0, adpe_pkg::SH_ASR, 4'd2)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_EOR, 1'b1, 4'd1, 4'd9,
                 reg_op(5'd0, adpe_pkg::SH_ROR, 4'd15)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b1, 4'd0, 4'd10,
                 imm_op(4'd4, 8'hFF)),
              4'd0, 32'd0, 1'b0, '0},
            // Compare-style opcodes and a move under the signed conditions.
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_GE, 1'b0, adpe_pkg::OP_TST, 1'b1, 4'd1, 4'd0,
                 reg_op(5'd31, adpe_pkg::SH_LSL, 4'd2)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_LT, 1'b0, adpe_pkg::OP_TEQ, 1'b1, 4'd2, 4'd0,
                 reg_op(5'd1, adpe_pkg::SH_ASR, 4'd2)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_GT, 1'b1, adpe_pkg::OP_CMP, 1'b1, 4'd15, 4'd0,
                 imm_op(4'd15, 8'hFF)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_LE, 1'b0, adpe_pkg::OP_MOV, 1'b0, 4'd7, 4'd11,
                 reg_op(5'd4, adpe_pkg::SH_ROR, 4'd1)),
              4'd0, 32'd0, 1'b0, '0},
            // Never-executing condition codes, an undefined opcode and a
            // register-specified shift.
            '{adpe_pkg::MODE_EXEC,
              dp(COND_NV, 1'b1, adpe_pkg::OP_MOV, 1'b1, 4'd0, 4'd12,
                 imm_op(4'd0, 8'h00)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(COND_HS, 1'b1, adpe_pkg::OP_ADD, 1'b1, 4'd1, 4'd12,
                 imm_op(4'd0, 8'h01)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b1, OP_RSC, 1'b1, 4'd1, 4'd12,
                 imm_op(4'd0, 8'h00)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_ADD, 1'b1, 4'd1, 4'd12,
                 reg_op(5'd0, adpe_pkg::SH_LSL, 4'd1) | REG_SHIFT_BIT),
              4'd0, 32'd0, 1'b0, '0},
            // Register 15 as an ordinary destination and source.
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1, 4'd0, 4'd15,
                 reg_op(5'd31, adpe_pkg::SH_LSR, 4'd2)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_EXEC,
              dp(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_ADD, 1'b0, 4'd15, 4'd14,
                 reg_op(5'd1, adpe_pkg::SH_LSL, 4'd15)),
              4'd0, 32'd0, 1'b0, '0},
            '{adpe_pkg::MODE_WRITE, 32'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, '0},
            '{adpe_pkg::MODE_READ, 32'd0, 4'd15, 32'd0, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < SCRIPT_LEN; k++) begin
            row = script[k];
            arch_step(row.mode, row.ins, row.idx, row.wv, want);
            if (row.typed) begin
                want = row.want;
            end
            offer(row.mode, row.ins, row.idx, row.wv);
            retire_q.push_back(want);
        end

        for (k = 0; k < RANDOM_LEN; k++) begin
            draw_item(md, ins, ix, wv);
            arch_step(md, ins, ix, wv, want);
            offer(md, ins, ix, wv);
            retire_q.push_back(want);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: every result in, then a further wait to catch extras.
        while (retire_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("alu_data_processing_execute_core verification clean");
        end else begin
            $display("alu_data_processing_execute_core verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off that fills the
    // pipeline and stalls the input, and a quiet window with no idling.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_cnt >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= calm() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: each transaction is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = m_axis_tdata[41:0];
            if (m_axis_tdata[adpe_pkg::OUT_TDATA_W-1:42] != '0) begin
                report("zero fill", 32'(m_axis_tdata[adpe_pkg::OUT_TDATA_W-1:42]), 32'd0);
            end
            if (retire_q.size() == 0) begin
                report("unexpected result", 32'(mon_got.value), 32'd0);
            end else begin
                mon_want = retire_q.pop_front();
                if (mon_got.executed !== mon_want.executed) begin
                    report("executed", 32'(mon_got.executed), 32'(mon_want.executed));
                end
                if (mon_got.wrote !== mon_want.wrote) begin
                    report("wrote_register", 32'(mon_got.wrote), 32'(mon_want.wrote));
                end
                if (mon_got.dest !== mon_want.dest) begin
                    report("dest_index", 32'(mon_got.dest), 32'(mon_want.dest));
                end
                if (mon_got.value !== mon_want.value) begin
                    report("result_value", mon_got.value, mon_want.value);
                end
                if (mon_got.flags !== mon_want.flags) begin
                    report("flags_nzcv", 32'(mon_got.flags), 32'(mon_want.flags));
                end
            end
            retired++;
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycle_cnt, retire_q.size());
                $display("alu_data_processing_execute_core verification failed");
                $finish;
            end
        end
    end

endmodule
